### design/qsu_pkg.sv
// Shared types and constants for the quoted string unescaper.
// Used by qsu_decode, qsu_out_buf and quoted_string_unescaper_unit.
// No dependencies.
package qsu_pkg;

  localparam int BYTE_W   = 8;
  localparam int TABS_W   = 6;
  localparam int REPORT_W = 16;

  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_T      = 8'h74;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_TABS = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_NOTSTR = 2'd3
  } kind_t;

  // One result word.
  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    kind_t               kind;
    logic [REPORT_W-1:0] lines_added;
    logic [REPORT_W-1:0] end_column;
    logic                last;
  } res_t;

  // Results produced by one input word: count (0..2) and the words in order.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

### design/qsu_decode.sv
// Combinational decode of one source byte against the current parser state.
// Depends on qsu_pkg.
module qsu_decode import qsu_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic [BYTE_W-1:0]      in_byte,
  input  logic                   at_end,
  input  logic [TABS_W-1:0]      indent_tabs,
  input  mode_t                  mode,
  input  logic [TABS_W-1:0]      tabs_left,
  input  logic [COUNT_WIDTH-1:0] line_count,
  input  logic [COUNT_WIDTH-1:0] column_count,
  output mode_t                  mode_nxt,
  output logic [TABS_W-1:0]      tabs_left_nxt,
  output logic [COUNT_WIDTH-1:0] line_count_nxt,
  output logic [COUNT_WIDTH-1:0] column_count_nxt,
  output push_t                  push
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam int XW = (COUNT_WIDTH > REPORT_W) ? COUNT_WIDTH : REPORT_W;
  localparam logic [XW-1:0] REPORT_MAX = XW'({REPORT_W{1'b1}});

  logic [COUNT_WIDTH-1:0] line_inc;
  logic [COUNT_WIDTH-1:0] col_inc1;
  logic [COUNT_WIDTH-1:0] col_inc2;
  logic [XW-1:0]          line_x;
  logic [XW-1:0]          col_x;
  logic [REPORT_W-1:0]    line_rep;
  logic [REPORT_W-1:0]    col_rep;

  // Saturating increments.
  assign line_inc = (line_count == CNT_MAX) ? CNT_MAX : line_count + COUNT_WIDTH'(1);
  assign col_inc1 = (column_count == CNT_MAX) ? CNT_MAX : column_count + COUNT_WIDTH'(1);
  assign col_inc2 = (column_count >= CNT_MAX - COUNT_WIDTH'(1)) ? CNT_MAX
                  : column_count + COUNT_WIDTH'(2);

  // Clamp reported counts to the 16-bit result fields.
  assign line_x   = XW'(line_count);
  assign col_x    = XW'(col_inc1);
  assign line_rep = (line_x > REPORT_MAX) ? {REPORT_W{1'b1}} : line_x[REPORT_W-1:0];
  assign col_rep  = (col_x > REPORT_MAX) ? {REPORT_W{1'b1}} : col_x[REPORT_W-1:0];

  always_comb begin
    mode_nxt         = mode;
    tabs_left_nxt    = tabs_left;
    line_count_nxt   = line_count;
    column_count_nxt = column_count;
    push             = '0;
    push.r0.kind     = KIND_DATA;
    push.r1.kind     = KIND_DATA;

    case (mode)
      MODE_IDLE: begin
        if (!at_end && in_byte == CH_QUOTE) begin
          mode_nxt         = MODE_STR;
          line_count_nxt   = '0;
          column_count_nxt = COUNT_WIDTH'(1);
        end else begin
          push.n       = 2'd1;
          push.r0.kind = KIND_NOTSTR;
        end
      end
      MODE_STR: begin
        if (at_end) begin
          push.n       = 2'd1;
          push.r0.kind = KIND_ERROR;
          mode_nxt     = MODE_IDLE;
        end else if (in_byte == CH_QUOTE) begin
          column_count_nxt    = col_inc1;
          push.n              = 2'd1;
          push.r0.kind        = KIND_DONE;
          push.r0.lines_added = line_rep;
          push.r0.end_column  = col_rep;
          mode_nxt            = MODE_IDLE;
        end else if (in_byte == CH_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else if (in_byte == CH_LF) begin
          push.n           = 2'd1;
          push.r0.out_byte = in_byte;
          line_count_nxt   = line_inc;
          column_count_nxt = '0;
          tabs_left_nxt    = indent_tabs;
          mode_nxt         = (indent_tabs == '0) ? MODE_STR : MODE_TABS;
        end else begin
          push.n           = 2'd1;
          push.r0.out_byte = in_byte;
          column_count_nxt = col_inc1;
        end
      end
      MODE_ESC: begin
        if (at_end) begin
          push.n       = 2'd1;
          push.r0.kind = KIND_ERROR;
          mode_nxt     = MODE_IDLE;
        end else if (in_byte == CH_LF) begin
          // Line join: no output, but still a new line.
          line_count_nxt   = line_inc;
          column_count_nxt = '0;
          tabs_left_nxt    = indent_tabs;
          mode_nxt         = (indent_tabs == '0) ? MODE_STR : MODE_TABS;
        end else begin
          push.n = 2'd1;
          if (in_byte == CH_N) begin
            push.r0.out_byte = CH_LF;
          end else if (in_byte == CH_T) begin
            push.r0.out_byte = CH_TAB;
          end else if (in_byte == CH_QUOTE || in_byte == CH_BSLASH) begin
            push.r0.out_byte = in_byte;
          end else begin
            // Unknown escape: pass the backslash and the byte.
            push.n           = 2'd2;
            push.r0.out_byte = CH_BSLASH;
            push.r1.out_byte = in_byte;
          end
          column_count_nxt = col_inc2;
          mode_nxt         = MODE_STR;
        end
      end
      MODE_TABS: begin
        if (!at_end && in_byte == CH_TAB) begin
          tabs_left_nxt = tabs_left - TABS_W'(1);
          if (tabs_left == TABS_W'(1)) begin
            mode_nxt = MODE_STR;
          end
        end else begin
          push.n        = 2'd1;
          push.r0.kind  = KIND_ERROR;
          mode_nxt      = MODE_IDLE;
          tabs_left_nxt = '0;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase

    // Flag the final word of this input.
    if (push.n == 2'd2) begin
      push.r1.last = 1'b1;
    end else if (push.n == 2'd1) begin
      push.r0.last = 1'b1;
    end
  end

endmodule

### design/qsu_out_buf.sv
// Two-entry result buffer: takes up to two words at once, drains one per cycle while res_ready is high.
// Depends on qsu_pkg.
module qsu_out_buf import qsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_en,
  input  push_t      push,
  output logic [1:0] count,
  output logic       res_valid,
  input  logic       res_ready,
  output res_t       res
);

  logic [1:0] count_r, count_nxt;
  res_t       slot0_r, slot0_nxt;
  res_t       slot1_r, slot1_nxt;
  logic       pop;
  logic [1:0] base;
  logic [1:0] n_in;

  assign pop  = (count_r != 2'd0) && res_ready;
  assign base = count_r - {1'b0, pop};
  assign n_in = push_en ? push.n : 2'd0;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (pop) begin
      slot0_nxt = slot1_r;
    end
    if (n_in != 2'd0) begin
      if (base == 2'd0) begin
        slot0_nxt = push.r0;
        slot1_nxt = push.r1;
      end else begin
        slot1_nxt = push.r0;
      end
    end
    count_nxt = base + n_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign count     = count_r;
  assign res_valid = (count_r != 2'd0);
  assign res       = slot0_r;

endmodule

### design/quoted_string_unescaper_unit.sv
// Top level of the quoted string unescaper: input register, parser state,
// decode and result buffer. Depends on qsu_pkg, qsu_decode and qsu_out_buf.
//
//  channel  direction  handshake              payload
//  in_      slave      in_tvalid/in_tready    tdata: in_byte; tuser: at_end
//  out_     master     out_tvalid/out_tready  tdata: out_byte, lines_added,
//                                             end_column; tuser: kind; tlast
//  cfg_     write      cfg_wr_en              cfg_wr_data: indent_tabs
//
// One word per cycle while the output buffer has room: a word is held in the input
// register, decoded in a single pass and its results are written into a two-entry
// output buffer, so out_tvalid rises after the edge that writes them and the first
// result then leaves from that buffer. A word that yields two results (unknown
// escape) waits until the buffer is empty, and the single-result word after it
// waits while both entries are full, so such a word stalls the input even with
// out_tready held high. Reset (rst_n low at a clock edge) returns the parser to
// idle, zeroes the counters and indent_tabs and empties both stages.
// When out_tready is low the buffer holds its words and the input register
// fills, then in_tready drops; in_tready never depends on out_tready in the
// same cycle.
module quoted_string_unescaper_unit import qsu_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input: tdata[7:0] in_byte; tuser[0] at_end
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  // output: tdata[7:0] out_byte, [23:8] lines_added, [39:24] end_column
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  // output: tuser[1:0] kind
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  // configuration: indent_tabs
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data
);

  // Configuration register.
  logic [TABS_W-1:0] indent_tabs_r;

  // Input register.
  logic              in_valid_r, in_valid_nxt;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_end_r;
  logic              in_accept;

  // Parser state.
  mode_t                  mode_r, mode_nxt;
  logic [TABS_W-1:0]      tabs_left_r, tabs_left_nxt;
  logic [COUNT_WIDTH-1:0] line_count_r, line_count_nxt;
  logic [COUNT_WIDTH-1:0] column_count_r, column_count_nxt;

  push_t      push;
  logic [1:0] buf_count;
  logic       fire;
  logic       room;
  res_t       res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      indent_tabs_r <= '0;
    end else if (cfg_wr_en) begin
      indent_tabs_r <= cfg_wr_data;
    end
  end

  qsu_decode #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_decode (
    .in_byte          (in_byte_r),
    .at_end           (in_end_r),
    .indent_tabs      (indent_tabs_r),
    .mode             (mode_r),
    .tabs_left        (tabs_left_r),
    .line_count       (line_count_r),
    .column_count     (column_count_r),
    .mode_nxt         (mode_nxt),
    .tabs_left_nxt    (tabs_left_nxt),
    .line_count_nxt   (line_count_nxt),
    .column_count_nxt (column_count_nxt),
    .push             (push)
  );

  // Room check looks only at registered buffer occupancy, never at out_tready.
  always_comb begin
    case (push.n)
      2'd0:    room = 1'b1;
      2'd1:    room = (buf_count != 2'd2);
      2'd2:    room = (buf_count == 2'd0);
      default: room = 1'b0;
    endcase
  end

  assign fire      = in_valid_r && room;
  assign in_tready = !in_valid_r || fire;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_accept) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  // Hold the input word until it is decoded; load a new one on accept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tuser;
    end
  end

  // Advance parser state only when the word is decoded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_IDLE;
      tabs_left_r    <= '0;
      line_count_r   <= '0;
      column_count_r <= '0;
    end else if (fire) begin
      mode_r         <= mode_nxt;
      tabs_left_r    <= tabs_left_nxt;
      line_count_r   <= line_count_nxt;
      column_count_r <= column_count_nxt;
    end
  end

  qsu_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (fire),
    .push      (push),
    .count     (buf_count),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {res.end_column, res.lines_added, res.out_byte};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

### tb/tb.sv
// Self-checking testbench for quoted_string_unescaper_unit: directed table, then random literals.
// Predicts result words in-line (or takes a typed one) and compares them with the output stream.
// Depends on qsu_pkg and the design sources.
`timescale 1ns / 100ps

module tb;
  import qsu_pkg::*;

  localparam int          CNT_W          = 16;
  localparam int unsigned CNT_MAX        = (32'd1 << CNT_W) - 1;
  localparam int          DRAIN_CYCLES   = 8;     // input register + decode + output buffer
  localparam int          HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int          WATCHDOG_LIMIT = 4000;  // cycles in which neither side moves a word
  localparam int          PHASE_ITEMS    = 160;
  localparam int          LONG_RUN       = 100;   // lines, then columns, in the long literal

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_wr_en;
  logic [5:0]  cfg_wr_data;

  quoted_string_unescaper_unit #(.COUNT_WIDTH(CNT_W)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Shadow of the parser: literal mode, owed indent tabs, line and column counters,
  // and the indent register as last written.
  mode_t       lit_mode;
  logic [5:0]  tabs_owed;
  logic [5:0]  indent_cfg;
  int unsigned line_cnt;
  int unsigned col_cnt;

  res_t        decoded_q[$];   // result words still owed by the block
  int          fail_cnt;
  int          item_cnt;

  // Sender pacing: burst length left, gaps enabled.
  int          burst_left;
  bit          gaps_on;

  // Receiver pattern and the one-shot long hold-off request.
  bit          hold_req;
  int          hold_left;
  int          rx_mode;
  int          rx_left;
  logic [7:0]  rx_phase;

  // A directed row may carry a hand-typed result that replaces the prediction.
  bit          typed_pending;
  res_t        typed_res;

  typedef struct packed {
    bit          is_cfg;   // write b[5:0] to indent_tabs instead of sending a word
    logic [7:0]  b;
    bit          e;
    bit          typed;
    kind_t       k;
    logic [15:0] ln;
    logic [15:0] col;
  } dir_row_t;

  dir_row_t    dir_q[$];

  function automatic void dir_add(bit is_cfg, logic [7:0] b, bit e, bit typed, kind_t k,
                                  logic [15:0] ln, logic [15:0] col);
    dir_row_t row;
    row.is_cfg = is_cfg;
    row.b      = b;
    row.e      = e;
    row.typed  = typed;
    row.k      = k;
    row.ln     = ln;
    row.col    = col;
    dir_q.push_back(row);
  endfunction

  function automatic void note_fail(string msg);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("%0t: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned sat_add(int unsigned v, int unsigned d);
    if (v >= CNT_MAX || CNT_MAX - v < d)
      return CNT_MAX;
    return v + d;
  endfunction

  // Reported counters are 16 bits wide whatever the counter width.
  function automatic logic [15:0] clamp_report(int unsigned v);
    return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic res_t mk_res(logic [7:0] b, kind_t k, int unsigned ln, int unsigned col);
    res_t r;
    r.out_byte    = b;
    r.kind        = k;
    r.lines_added = clamp_report(ln);
    r.end_column  = clamp_report(col);
    r.last        = 1'b0;
    return r;
  endfunction

  // Count the line, restart the column and latch the indent owed on the new line.
  function automatic void take_newline();
    line_cnt  = sat_add(line_cnt, 1);
    col_cnt   = 0;
    tabs_owed = indent_cfg;
    lit_mode  = (indent_cfg == 0) ? MODE_STR : MODE_TABS;
  endfunction

  // Advance the shadow parser by one input word; return the number of result words.
  function automatic int unescape_step(input logic [7:0] b, input logic e,
                                       output res_t r0, output res_t r1);
    res_t slot [0:1];
    int   n;
    n       = 0;
    slot[0] = '0;
    slot[1] = '0;
    case (lit_mode)
      MODE_IDLE: begin
        if (!e && b == CH_QUOTE) begin
          lit_mode = MODE_STR;
          line_cnt = 0;
          col_cnt  = 1;
        end else begin
          slot[n] = mk_res(8'h00, KIND_NOTSTR, 0, 0);
          n++;
        end
      end
      MODE_STR: begin
        if (e) begin
          slot[n] = mk_res(8'h00, KIND_ERROR, 0, 0);
          n++;
          lit_mode = MODE_IDLE;
        end else if (b == CH_QUOTE) begin
          col_cnt = sat_add(col_cnt, 1);
          slot[n] = mk_res(8'h00, KIND_DONE, line_cnt, col_cnt);
          n++;
          lit_mode = MODE_IDLE;
        end else if (b == CH_BSLASH) begin
          lit_mode = MODE_ESC;
        end else if (b == CH_LF) begin
          slot[n] = mk_res(b, KIND_DATA, 0, 0);
          n++;
          take_newline();
        end else begin
          slot[n] = mk_res(b, KIND_DATA, 0, 0);
          n++;
          col_cnt = sat_add(col_cnt, 1);
        end
      end
      MODE_ESC: begin
        if (e) begin
          slot[n] = mk_res(8'h00, KIND_ERROR, 0, 0);
          n++;
          lit_mode = MODE_IDLE;
        end else if (b == CH_LF) begin
          take_newline();
        end else begin
          if (b == CH_N) begin
            slot[n] = mk_res(CH_LF, KIND_DATA, 0, 0);
            n++;
          end else if (b == CH_T) begin
            slot[n] = mk_res(CH_TAB, KIND_DATA, 0, 0);
            n++;
          end else if (b == CH_QUOTE || b == CH_BSLASH) begin
            slot[n] = mk_res(b, KIND_DATA, 0, 0);
            n++;
          end else begin
            // unknown escape: pass the backslash and the byte through
            slot[n] = mk_res(CH_BSLASH, KIND_DATA, 0, 0);
            n++;
            slot[n] = mk_res(b, KIND_DATA, 0, 0);
            n++;
          end
          col_cnt  = sat_add(col_cnt, 2);
          lit_mode = MODE_STR;
        end
      end
      default: begin
        if (!e && b == CH_TAB) begin
          tabs_owed = tabs_owed - 6'd1;
          if (tabs_owed == 0)
            lit_mode = MODE_STR;
        end else begin
          slot[n] = mk_res(8'h00, KIND_ERROR, 0, 0);
          n++;
          lit_mode  = MODE_IDLE;
          tabs_owed = 0;
        end
      end
    endcase
    if (n > 0)
      slot[n-1].last = 1'b1;
    r0 = slot[0];
    r1 = slot[1];
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one word, hold it until accepted, then predict its results.
  // Called right after a rising edge; returns right after the accepting edge.
  task automatic put_word(input logic [7:0] b, input logic e);
    res_t r0, r1;
    int   n;
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      // mostly short bursts, now and then a long unbroken one
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 200) : $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= e;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    n = unescape_step(b, e, r0, r1);
    if (typed_pending) begin
      decoded_q.push_back(typed_res);
      typed_pending = 1'b0;
    end else begin
      if (n > 0) decoded_q.push_back(r0);
      if (n > 1) decoded_q.push_back(r1);
    end
    item_cnt++;
  endtask

  // Write indent_tabs only once the block has drained and gone quiet.
  task automatic set_indent(input logic [5:0] v);
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    indent_cfg   = v;
  endtask

  // Indent tabs after a newline: usually the full count, sometimes short and then
  // broken by a non-tab byte or the end of source. broke tells the caller to drop the literal.
  task automatic emit_tabs(output bit broke);
    int         cnt;
    bit         short_run;
    logic [7:0] b;
    short_run = (indent_cfg != 0) && ($urandom_range(0, 9) == 0);
    cnt       = short_run ? $urandom_range(0, int'(indent_cfg) - 1) : int'(indent_cfg);
    repeat (cnt) put_word(CH_TAB, 1'b0);
    broke = short_run;
    if (short_run) begin
      if ($urandom_range(0, 3) == 0) begin
        b = 8'($urandom_range(0, 255));
        put_word(b, 1'b1);
      end else begin
        b = 8'($urandom_range(0, 255));
        while (b == CH_TAB) b = 8'($urandom_range(0, 255));
        put_word(b, 1'b0);
      end
    end
  endtask

  // One random literal: mostly well formed with random content, sometimes broken.
  task automatic gen_literal();
    int         len;
    int         r;
    bit         broke;
    logic [7:0] b;
    broke = 1'b0;
    if ($urandom_range(0, 11) == 0) begin
      // not a string at all
      b = 8'($urandom_range(0, 255));
      while (b == CH_QUOTE) b = 8'($urandom_range(0, 255));
      put_word(b, 1'b0);
      return;
    end
    put_word(CH_QUOTE, 1'b0);
    len = $urandom_range(0, 24);
    for (int i = 0; i < len && !broke; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50 || r >= 88) begin
        // plain byte, tab and control bytes included
        b = 8'($urandom_range(0, 255));
        while (b == CH_QUOTE || b == CH_BSLASH || b == CH_LF) b = 8'($urandom_range(0, 255));
        put_word(b, 1'b0);
      end else if (r < 60) begin
        put_word(CH_BSLASH, 1'b0);
        case ($urandom_range(0, 3))
          0:       put_word(CH_N, 1'b0);
          1:       put_word(CH_T, 1'b0);
          2:       put_word(CH_QUOTE, 1'b0);
          default: put_word(CH_BSLASH, 1'b0);
        endcase
      end else if (r < 68) begin
        // unknown escape
        b = 8'($urandom_range(0, 255));
        while (b == CH_N || b == CH_T || b == CH_QUOTE || b == CH_BSLASH || b == CH_LF)
          b = 8'($urandom_range(0, 255));
        put_word(CH_BSLASH, 1'b0);
        put_word(b, 1'b0);
      end else if (r < 78) begin
        put_word(CH_LF, 1'b0);
        emit_tabs(broke);
      end else if (r < 84) begin
        // line join
        put_word(CH_BSLASH, 1'b0);
        put_word(CH_LF, 1'b0);
        emit_tabs(broke);
      end else begin
        // any byte at all; may close the literal early or open an escape
        b = 8'($urandom_range(0, 255));
        put_word(b, 1'b0);
      end
    end
    if (broke)
      return;
    r = $urandom_range(0, 19);
    if (r < 16) begin
      put_word(CH_QUOTE, 1'b0);
    end else if (r < 18) begin
      b = 8'($urandom_range(0, 255));
      put_word(b, 1'b1);
    end
    // otherwise leave it open; a later quote or end of source closes it
  endtask

  // One random phase at a given indent; optionally with the long receiver hold-off.
  task automatic run_phase(input logic [5:0] indent, input bit pressure);
    int         start;
    logic [7:0] b;
    set_indent(indent);
    if (pressure) begin
      // keep offering words while the receiver holds off, so the block backs up
      gaps_on  = 1'b0;
      hold_req = 1'b1;
    end
    start = item_cnt;
    while (item_cnt - start < PHASE_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          b = 8'($urandom_range(0, 255));
          put_word(b, $urandom_range(0, 9) == 0);
        end
      end
      gen_literal();
    end
    // end of source: return the parser to idle whatever its state
    b = 8'($urandom_range(0, 255));
    put_word(b, 1'b1);
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: its own stall pattern plus the one long hold-off
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req   = 1'b0;
      hold_left  = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(16, 128);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= ($urandom_range(0, 4) != 0);
        default: out_tready <= (rx_phase[1:0] == 2'd0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker and watchdog
  // ---------------------------------------------------------------------------

  res_t got_res;
  res_t want_res;
  int   quiet_cycles;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res.out_byte    = out_tdata[7:0];
      got_res.lines_added = out_tdata[23:8];
      got_res.end_column  = out_tdata[39:24];
      got_res.kind        = kind_t'(out_tuser);
      got_res.last        = out_tlast;
      if (decoded_q.size() == 0) begin
        note_fail($sformatf("unexpected word: byte %02h kind %0d lines %0d col %0d last %0b",
                            got_res.out_byte, got_res.kind, got_res.lines_added,
                            got_res.end_column, got_res.last));
      end else begin
        want_res = decoded_q.pop_front();
        if (got_res.out_byte    !== want_res.out_byte    ||
            got_res.kind        !== want_res.kind        ||
            got_res.lines_added !== want_res.lines_added ||
            got_res.end_column  !== want_res.end_column  ||
            got_res.last        !== want_res.last)
          note_fail($sformatf({"mismatch: exp byte %02h kind %0d lines %0d col %0d last %0b",
                               " / got byte %02h kind %0d lines %0d col %0d last %0b"},
                              want_res.out_byte, want_res.kind, want_res.lines_added,
                              want_res.end_column, want_res.last,
                              got_res.out_byte, got_res.kind, got_res.lines_added,
                              got_res.end_column, got_res.last));
      end
    end
  end

  // Count cycles in which neither side moves a word.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= 8'h00;
    in_tuser    <= 1'b0;
    out_tready  <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 6'd0;
    lit_mode      = MODE_IDLE;
    tabs_owed     = 0;
    indent_cfg    = 0;
    line_cnt      = 0;
    col_cnt       = 0;
    fail_cnt      = 0;
    item_cnt      = 0;
    burst_left    = 0;
    gaps_on       = 1'b1;
    hold_req      = 1'b0;
    hold_left     = 0;
    rx_mode       = 0;
    rx_left       = 0;
    rx_phase      = 0;
    quiet_cycles  = 0;
    typed_pending = 1'b0;

    // Directed rows. Typed results only where they are obvious: status words.
    // end of source while idle, stray byte while idle
    dir_add(0, 8'hFF,     1, 1, KIND_NOTSTR, 0, 0);
    dir_add(0, 8'h61,     0, 1, KIND_NOTSTR, 0, 0);
    // empty literal: both quotes on one line
    dir_add(0, CH_QUOTE,  0, 0, KIND_DATA,   0, 0);
    dir_add(0, CH_QUOTE,  0, 1, KIND_DONE,   0, 2);
    // byte extremes, known and unknown escapes, line join, plain newline
    dir_add(0, CH_QUOTE,  0, 0, KIND_DATA,   0, 0);
    dir_add(0, 8'h00,     0, 0, KIND_DATA,   0, 0);
    dir_add(0, 8'hFF,     0, 0, KIND_DATA,   0, 0);
    dir_add(0, CH_BSLASH, 0, 0, KIND_DATA,   0, 0);
    dir_add(0, CH_N,      0, 0, KIND_DATA,   0, 0);
    dir_add(0, CH_BSLASH, 0, 0, KIND_DATA,   0, 0);
    dir_add(0, CH_BSLASH, 0, 0, KIND_DATA,   0, 0);
    dir_add(0, CH_BSLASH, 0, 0, KIND_DATA,   0, 0);
    dir_add(0, 8'h71,     0, 0, KIND_DATA,   0, 0);
    dir_add(0, CH_BSLASH, 0, 0, KIND_DATA,   0, 0);
    dir_add(0, CH_LF,     0, 0, KIND_DATA,   0, 0);
    dir_add(0, CH_LF,     0, 0, KIND_DATA,   0, 0);
    dir_add(0, CH_QUOTE,  0, 0, KIND_DATA,   0, 0);
    // source ends inside the literal
    dir_add(0, CH_QUOTE,  0, 0, KIND_DATA,   0, 0);
    dir_add(0, 8'h00,     1, 1, KIND_ERROR,  0, 0);
    // two tabs of indent; joined line with only one tab
    dir_add(1, 8'd2,      0, 0, KIND_DATA,   0, 0);
    dir_add(0, CH_QUOTE,  0, 0, KIND_DATA,   0, 0);
    dir_add(0, CH_BSLASH, 0, 0, KIND_DATA,   0, 0);
    dir_add(0, CH_LF,     0, 0, KIND_DATA,   0, 0);
    dir_add(0, CH_TAB,    0, 0, KIND_DATA,   0, 0);
    dir_add(0, 8'h62,     0, 1, KIND_ERROR,  0, 0);
    // source ends right after a backslash
    dir_add(0, CH_QUOTE,  0, 0, KIND_DATA,   0, 0);
    dir_add(0, CH_BSLASH, 0, 0, KIND_DATA,   0, 0);
    dir_add(0, 8'h55,     1, 1, KIND_ERROR,  0, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_q[i]) begin
      if (dir_q[i].is_cfg) begin
        set_indent(dir_q[i].b[5:0]);
      end else begin
        if (dir_q[i].typed) begin
          typed_pending = 1'b1;
          typed_res     = mk_res(8'h00, dir_q[i].k, dir_q[i].ln, dir_q[i].col);
          typed_res.last = 1'b1;
        end
        put_word(dir_q[i].b, dir_q[i].e);
      end
    end

    // Random phases across indent settings, the extremes among them.
    run_phase(6'd63, 1'b0);
    run_phase(6'd1,  1'b1);
    run_phase(6'd0,  1'b0);
    run_phase(6'd5,  1'b0);
    run_phase(6'($urandom_range(0, 63)), 1'b0);
    run_phase(6'($urandom_range(0, 63)), 1'b0);
    run_phase(6'd17, 1'b0);
    run_phase(6'($urandom_range(0, 63)), 1'b0);

    // Long literal: many lines back to back, then a long last line,
    // an unknown escape and the closing quote.
    set_indent(6'd0);
    gaps_on = 1'b0;
    put_word(CH_QUOTE, 1'b0);
    repeat (LONG_RUN) put_word(CH_LF, 1'b0);
    repeat (LONG_RUN) put_word(8'h61, 1'b0);
    put_word(CH_BSLASH, 1'b0);
    put_word(8'h71, 1'b0);
    put_word(CH_QUOTE, 1'b0);
    gaps_on = 1'b1;

    // Drain, then allow stray words to show up before the verdict.
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (fail_cnt == 0 && decoded_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
design/qsu_pkg.sv
design/qsu_decode.sv
design/qsu_out_buf.sv
design/quoted_string_unescaper_unit.sv
tb/tb.sv
